### hw/rtl/fr_pkg.sv
// shared types and constants of the fragment reassembler
package fr_pkg;

   // sizing
   localparam int MAX_FRAGS  = 16;
   localparam int SLOT_BYTES = 1024;
   localparam int MAX_FRAME  = 8192;
   localparam int SLOT_W     = $clog2(MAX_FRAGS);
   localparam int OFF_W      = $clog2(SLOT_BYTES);
   localparam int SLEN_W     = $clog2(SLOT_BYTES + 1);
   localparam int STORE_AW   = SLOT_W + OFF_W;
   localparam int FB_AW      = $clog2(MAX_FRAME);
   localparam int CNT_W      = 5;
   localparam int LEN_W      = 14;
   localparam int TOTAL_W    = 15;

   // register indexes
   localparam logic REG_MAX_FRAGMENTS   = 1'b0;
   localparam logic REG_MAX_FRAME_BYTES = 1'b1;

   // result status codes
   localparam logic [3:0] ST_STORED    = 4'd0;
   localparam logic [3:0] ST_DUP       = 4'd1;
   localparam logic [3:0] ST_BAD_COUNT = 4'd2;
   localparam logic [3:0] ST_BAD_INDEX = 4'd3;
   localparam logic [3:0] ST_NO_FRAME  = 4'd4;
   localparam logic [3:0] ST_RANGE     = 4'd5;
   localparam logic [3:0] ST_READY     = 4'd6;
   localparam logic [3:0] ST_MISSING   = 4'd7;
   localparam logic [3:0] ST_TOO_LARGE = 4'd8;
   localparam logic [3:0] ST_OVERFLOW  = 4'd9;
   localparam logic [3:0] ST_READ      = 4'd10;
   localparam logic [3:0] ST_NOTHING   = 4'd11;

   // kind of a queued beat
   typedef enum logic [1:0] {
      CMD_READ,
      CMD_HEAD,
      CMD_BODY
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   frag_index;
      logic [7:0]   frag_count;
      logic         byte_valid;
      logic [7:0]   data_byte;
      logic         last_byte;
   } cmd_type;

endpackage

### hw/rtl/fr_front.sv
// front end: accepts beats, tags them as read, header or body, and queues them
module fr_front import fr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    req_op,
   input  logic [7:0] req_frag_index,
   input  logic [7:0] req_frag_count,
   input  logic    req_byte_valid,
   input  logic [7:0] req_data_byte,
   input  logic    req_last_byte,
   output logic    q_valid,
   output cmd_type q_item,
   input  logic    q_pop
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       in_frag_ff;
   logic       push;
   cmd_type    beat_cmd;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entry_ff[rd_ptr_ff];

   // classify the incoming beat
   always_comb begin
      beat_cmd.kind       = req_op ? CMD_READ : (in_frag_ff ? CMD_BODY : CMD_HEAD);
      beat_cmd.frag_index = req_frag_index;
      beat_cmd.frag_count = req_frag_count;
      beat_cmd.byte_valid = req_byte_valid;
      beat_cmd.data_byte  = req_data_byte;
      beat_cmd.last_byte  = req_last_byte;
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= beat_cmd;
      end
   end

   // pointers and fragment tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= 1'b0;
         rd_ptr_ff  <= 1'b0;
         count_ff   <= 2'd0;
         in_frag_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(q_pop);
         if (push && !req_op) begin
            in_frag_ff <= !req_last_byte;
         end
      end
   end

endmodule

### hw/rtl/fr_back.sv
// back end: slot bookkeeping, completion walk, frame copy and read-out
module fr_back import fr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] max_frag,
   input  logic [LEN_W-1:0] max_bytes,
   input  logic             q_valid,
   input  cmd_type          q_item,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [3:0]       rsp_status,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_frame_end,
   output logic [LEN_W-1:0] rsp_frame_length
);

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_CHECK, S_DECIDE, S_COPY, S_DRAIN, S_FIN
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   expected_ff, expected_in, received_ff, received_in;
   logic               accepted_ff, accepted_in;
   logic [SLOT_W-1:0]  cur_slot_ff, cur_slot_in;
   logic [SLEN_W-1:0]  slot_len_ff [MAX_FRAGS];
   logic [SLEN_W-1:0]  slot_len_in [MAX_FRAGS];
   logic [LEN_W-1:0]   ready_len_ff, ready_len_in, read_pos_ff, read_pos_in;
   logic [SLOT_W-1:0]  chk_idx_ff, chk_idx_in, cp_slot_ff, cp_slot_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               miss_ff, miss_in;
   logic [OFF_W-1:0]   cp_off_ff, cp_off_in;
   logic [FB_AW-1:0]   wr_pos_ff, wr_pos_in;
   logic               pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in, rsp_end_ff, rsp_end_in;
   logic [3:0]         rsp_status_ff, rsp_status_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic [LEN_W-1:0]   rsp_len_ff, rsp_len_in;

   logic [7:0]          store_mem [MAX_FRAGS * SLOT_BYTES];
   logic [7:0]          fb_mem [MAX_FRAME];
   logic [7:0]          store_rd_ff, fb_rd_ff;
   logic                store_we;
   logic [STORE_AW-1:0] store_waddr, store_raddr;

   logic               out_free, emit, do_byte, is_head;
   logic [3:0]         emit_status;
   logic [SLOT_W-1:0]  sl_addr, byte_slot;
   logic [SLEN_W-1:0]  sl_rd, byte_len;
   logic [CNT_W-1:0]   lim_frag, exp_eff, exp_last;
   logic [LEN_W-1:0]   lim_bytes;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign lim_frag  = (max_frag > CNT_W'(MAX_FRAGS)) ? CNT_W'(MAX_FRAGS) : max_frag;
   assign lim_bytes = (max_bytes > LEN_W'(MAX_FRAME)) ? LEN_W'(MAX_FRAME) : max_bytes;
   assign exp_last  = expected_ff - CNT_W'(1);
   assign is_head   = (q_item.kind == CMD_HEAD);
   assign exp_eff   = (q_item.frag_index == 8'd0) ? q_item.frag_count[CNT_W-1:0] : expected_ff;
   assign sl_rd     = slot_len_ff[sl_addr];
   assign byte_slot = is_head ? q_item.frag_index[SLOT_W-1:0] : cur_slot_ff;
   assign byte_len  = is_head ? '0 : sl_rd;
   assign store_waddr = {byte_slot, byte_len[OFF_W-1:0]};
   assign store_raddr = {cp_slot_ff, cp_off_ff};

   // single slot length read port, address by state
   always_comb begin
      case (state_ff)
         S_CHECK: sl_addr = chk_idx_ff;
         S_COPY:  sl_addr = cp_slot_ff;
         default: sl_addr = is_head ? q_item.frag_index[SLOT_W-1:0] : cur_slot_ff;
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      expected_in   = expected_ff;
      received_in   = received_ff;
      accepted_in   = accepted_ff;
      cur_slot_in   = cur_slot_ff;
      slot_len_in   = slot_len_ff;
      ready_len_in  = ready_len_ff;
      read_pos_in   = read_pos_ff;
      chk_idx_in    = chk_idx_ff;
      total_in      = total_ff;
      miss_in       = miss_ff;
      cp_slot_in    = cp_slot_ff;
      cp_off_in     = cp_off_ff;
      wr_pos_in     = pend_ff ? wr_pos_ff + FB_AW'(1) : wr_pos_ff;
      pend_in       = 1'b0;
      q_pop         = 1'b0;
      store_we      = 1'b0;
      do_byte       = 1'b0;
      emit          = 1'b0;
      emit_status   = ST_STORED;
      rsp_byte_in   = 8'd0;
      rsp_end_in    = 1'b0;
      rsp_len_in    = '0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               case (q_item.kind)
                  CMD_READ: begin
                     if (ready_len_ff == '0 || read_pos_ff >= ready_len_ff) begin
                        emit        = 1'b1;
                        emit_status = ST_NOTHING;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  CMD_HEAD: begin
                     accepted_in = 1'b0;
                     if (q_item.frag_count == 8'd0 || q_item.frag_count > 8'(lim_frag)) begin
                        emit        = 1'b1;
                        emit_status = ST_BAD_COUNT;
                     end else if (q_item.frag_index >= q_item.frag_count) begin
                        emit        = 1'b1;
                        emit_status = ST_BAD_INDEX;
                     end else begin
                        if (q_item.frag_index == 8'd0) begin
                           for (int k = 0; k < MAX_FRAGS; k++) begin
                              slot_len_in[k] = '0;
                           end
                           expected_in = q_item.frag_count[CNT_W-1:0];
                           received_in = '0;
                        end
                        if (exp_eff == '0) begin
                           emit        = 1'b1;
                           emit_status = ST_NO_FRAME;
                        end else if (q_item.frag_index >= 8'(exp_eff)) begin
                           emit        = 1'b1;
                           emit_status = ST_RANGE;
                        end else if (q_item.frag_index != 8'd0 && sl_rd != '0) begin
                           emit        = 1'b1;
                           emit_status = ST_DUP;
                        end else begin
                           accepted_in = 1'b1;
                           cur_slot_in = q_item.frag_index[SLOT_W-1:0];
                           do_byte     = 1'b1;
                        end
                     end
                  end
                  CMD_BODY: begin
                     do_byte = accepted_ff;
                  end
                  default: ;
               endcase
               // payload byte and end of fragment
               if (do_byte) begin
                  if (q_item.byte_valid && byte_len >= SLEN_W'(SLOT_BYTES)) begin
                     slot_len_in[byte_slot] = '0;
                     accepted_in            = 1'b0;
                     emit                   = 1'b1;
                     emit_status            = ST_OVERFLOW;
                  end else begin
                     if (q_item.byte_valid) begin
                        store_we               = 1'b1;
                        slot_len_in[byte_slot] = byte_len + SLEN_W'(1);
                     end
                     if (q_item.last_byte) begin
                        accepted_in = 1'b0;
                        if (received_in != '1) begin
                           received_in = received_in + CNT_W'(1);
                        end
                        if (received_in < expected_in) begin
                           emit        = 1'b1;
                           emit_status = ST_STORED;
                        end else begin
                           state_in   = S_CHECK;
                           chk_idx_in = '0;
                           total_in   = '0;
                           miss_in    = 1'b0;
                        end
                     end
                  end
               end
            end
         end
         S_READ: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_status = ST_READ;
               rsp_byte_in = fb_rd_ff;
               rsp_len_in  = ready_len_ff;
               rsp_end_in  = (read_pos_ff + LEN_W'(1) == ready_len_ff);
               if (rsp_end_in) begin
                  ready_len_in = '0;
                  read_pos_in  = '0;
               end else begin
                  read_pos_in = read_pos_ff + LEN_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         // walk the slots: any empty, and the total length
         S_CHECK: begin
            miss_in  = miss_ff || (sl_rd == '0);
            total_in = total_ff + TOTAL_W'(sl_rd);
            if (CNT_W'(chk_idx_ff) == exp_last) begin
               state_in = S_DECIDE;
            end else begin
               chk_idx_in = chk_idx_ff + SLOT_W'(1);
            end
         end
         S_DECIDE: begin
            if (miss_ff || total_ff > TOTAL_W'(lim_bytes)) begin
               if (out_free) begin
                  emit        = 1'b1;
                  emit_status = miss_ff ? ST_MISSING : ST_TOO_LARGE;
                  state_in    = S_IDLE;
               end
            end else begin
               cp_slot_in = '0;
               cp_off_in  = '0;
               wr_pos_in  = '0;
               state_in   = S_COPY;
            end
         end
         // one store read per cycle, written to the frame buffer in the next cycle
         S_COPY: begin
            pend_in = 1'b1;
            if (SLEN_W'(cp_off_ff) + SLEN_W'(1) == sl_rd) begin
               cp_off_in = '0;
               if (CNT_W'(cp_slot_ff) == exp_last) begin
                  state_in = S_DRAIN;
               end else begin
                  cp_slot_in = cp_slot_ff + SLOT_W'(1);
               end
            end else begin
               cp_off_in = cp_off_ff + OFF_W'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               emit         = 1'b1;
               emit_status  = ST_READY;
               rsp_len_in   = total_ff[LEN_W-1:0];
               ready_len_in = total_ff[LEN_W-1:0];
               read_pos_in  = '0;
               for (int k = 0; k < MAX_FRAGS; k++) begin
                  slot_len_in[k] = '0;
               end
               expected_in = '0;
               received_in = '0;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_status_in = emit_status;
      rsp_valid_in  = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // fragment store
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_waddr] <= q_item.data_byte;
      end
      store_rd_ff <= store_mem[store_raddr];
   end

   // frame buffer
   always_ff @(posedge clock) begin
      if (pend_ff) begin
         fb_mem[wr_pos_ff] <= store_rd_ff;
      end
      fb_rd_ff <= fb_mem[read_pos_ff[FB_AW-1:0]];
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         expected_ff  <= '0;
         received_ff  <= '0;
         accepted_ff  <= 1'b0;
         cur_slot_ff  <= '0;
         for (int k = 0; k < MAX_FRAGS; k++) begin
            slot_len_ff[k] <= '0;
         end
         ready_len_ff <= '0;
         read_pos_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         expected_ff  <= expected_in;
         received_ff  <= received_in;
         accepted_ff  <= accepted_in;
         cur_slot_ff  <= cur_slot_in;
         slot_len_ff  <= slot_len_in;
         ready_len_ff <= ready_len_in;
         read_pos_ff  <= read_pos_in;
         chk_idx_ff   <= chk_idx_in;
         total_ff     <= total_in;
         miss_ff      <= miss_in;
         cp_slot_ff   <= cp_slot_in;
         cp_off_ff    <= cp_off_in;
         wr_pos_ff    <= wr_pos_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (emit) begin
            rsp_status_ff <= rsp_status_in;
            rsp_byte_ff   <= rsp_byte_in;
            rsp_end_ff    <= rsp_end_in;
            rsp_len_ff    <= rsp_len_in;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_frame_end    = rsp_end_ff;
   assign rsp_frame_length = rsp_len_ff;

endmodule

### hw/rtl/fragment_reassembler_top.sv
// top level of the fragment reassembler: config registers, front and back ends
//
// req_ channel: one beat per fragment byte (op 0) or per frame byte read (op 1).
// rsp_ channel: at most one result beat per request beat, in request order.
// csr_ port: write max_fragments (index 0) or max_frame_bytes (index 1) while idle.
// Beats enter a two-entry queue, so up to two beats are taken while a result waits.
// A fragment byte is handled in the back end's idle state; a read also passes
// through S_READ for the registered frame buffer read.
// The last fragment of a frame starts a completion: a walk over the expected
// slots to check lengths, then status 7 or 8 on an empty slot or too large a
// frame, else a copy of each frame byte from the fragment store to the frame
// buffer (one store read port), then S_DRAIN and S_FIN, and status 6.
// Reset clears slot lengths, fragment counters and queue pointers, not the walk
// and copy counters; both memories keep their contents; no clearing pass is run.
// When rsp_ready is low the result register holds; the back end waits to pop or
// emit once it is full, and req_ready drops when the queue has two beats.
module fragment_reassembler_top import fr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_frag_index,
   input  logic [7:0]  req_frag_count,
   input  logic        req_byte_valid,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_status,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_end,
   output logic [13:0] rsp_frame_length,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [13:0] csr_wdata
);

   logic [CNT_W-1:0] max_frag_ff;
   logic [LEN_W-1:0] max_bytes_ff;
   logic             q_valid, q_pop;
   cmd_type          q_item;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_frag_ff  <= CNT_W'(MAX_FRAGS);
         max_bytes_ff <= LEN_W'(MAX_FRAME);
      end else if (csr_wr_en) begin
         if (csr_index == REG_MAX_FRAGMENTS) begin
            max_frag_ff <= csr_wdata[CNT_W-1:0];
         end
         if (csr_index == REG_MAX_FRAME_BYTES) begin
            max_bytes_ff <= csr_wdata;
         end
      end
   end

   fr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_frag_index (req_frag_index),
      .req_frag_count (req_frag_count),
      .req_byte_valid (req_byte_valid),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   fr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .max_frag         (max_frag_ff),
      .max_bytes        (max_bytes_ff),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_frame_length (rsp_frame_length)
   );

   // frame end only on a read beat
   a_end_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_status == ST_READ)
      else $error("frame end on a non-read beat");

   // a data byte only on a read beat
   a_byte_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_READ |-> rsp_out_byte == 8'd0)
      else $error("data byte on a non-read beat");

   // a queue pop always loads or leaves free the result register
   a_pop_room: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !rsp_valid || rsp_ready)
      else $error("queue popped while result register full");

endmodule
